// ===== hw/rtl/hbs_pkg.sv =====
`timescale 1ns / 1ps
package hbs_pkg;

   localparam int MAP_WIDTH  = 256;
   localparam int MAP_HEIGHT = 256;

   localparam int AW       = 16;                      // heightmap address bits
   localparam int HM_DEPTH = 1 << AW;
   localparam int XW       = $clog2(MAP_WIDTH);       // texel column index bits
   localparam int ZW       = $clog2(MAP_HEIGHT);      // texel row index bits
   localparam int SXW      = $clog2(MAP_WIDTH + 1);   // bits that hold MAP_WIDTH
   localparam int SZW      = $clog2(MAP_HEIGHT + 1);
   localparam int PROD_W   = 56;                      // delta * inverse scale
   localparam int FXW      = PROD_W + SXW;
   localparam int FZW      = PROD_W + SZW;
   localparam int PXW      = FXW - 16;                // texel coordinate, Q.16
   localparam int PZW      = FZW - 16;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CSR_IW-1:0] REG_OFFSET_X     = 3'd0;
   localparam logic [CSR_IW-1:0] REG_OFFSET_Z     = 3'd1;
   localparam logic [CSR_IW-1:0] REG_INV_SCALE_X  = 3'd2;
   localparam logic [CSR_IW-1:0] REG_INV_SCALE_Z  = 3'd3;
   localparam logic [CSR_IW-1:0] REG_OUT_GAIN     = 3'd4;
   localparam logic [CSR_IW-1:0] REG_OUT_OFFSET_Y = 3'd5;

   localparam logic [23:0] INV_SCALE_RESET = 24'd65536;
   localparam logic [23:0] OUT_GAIN_RESET  = 24'd6579;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_z;
      logic [23:0]        inv_scale_x;
      logic [23:0]        inv_scale_z;
      logic [23:0]        out_gain;
      logic signed [31:0] out_offset_y;
   } cfg_type;

   // item leaving the coordinate mapping stages
   typedef struct packed {
      func_type       func;
      logic [AW-1:0]  texel_addr;
      logic [7:0]     texel_value;
      logic           outside;
      logic [XW-1:0]  ix;
      logic [ZW-1:0]  iz;
      logic [15:0]    fx;
      logic [15:0]    fz;
   } map_item_type;

   // query leaving the fetch stage; the last texel follows on the read port
   typedef struct packed {
      logic        outside;
      logic [15:0] fx;
      logic [15:0] fz;
      logic [7:0]  h00;
      logic [7:0]  h10;
      logic [7:0]  h01;
   } fetch_item_type;

endpackage

// ===== hw/rtl/heightmap_bilinear_sampler_top.sv =====
`timescale 1ns / 1ps
// Heightmap bilinear sampler.
// The req channel carries two kinds of item. A write item (req_func = 0)
// stores req_texel_value at req_texel_addr of the 64K x 8 heightmap and
// gives no result. A query item (req_func = 1) maps req_query_x/z into
// texel space, reads the four texels around the point and returns one rsp
// item: the blended, gained and offset height, or 0 with rsp_outside set
// when the point lies outside the map.
// Items are accepted when valid is high and stall is low; results leave in
// order. A query holds the single-port heightmap memory for its four reads
// (one read a cycle), so the next item waits until they are done and the
// query is handed on; a write holds it for its one write, and an outside
// query makes no read.
// A stalled result waits in the output register while the mapping stages
// keep taking items until the pipeline fills; then req_stall rises.
// Synchronous reset empties the pipeline and loads the register defaults;
// the heightmap is not cleared, so every texel read must first be written.
// The csr port writes the register at csr_index; write it only while idle.
module heightmap_bilinear_sampler_top
   import hbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [CSR_DW-1:0]  csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [15:0]        req_texel_addr,
   input  logic [7:0]         req_texel_value,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_terrain_height,
   output logic               rsp_outside
);

   cfg_type        cfg_ff;
   logic           in_ready;
   logic           map_valid, map_ready;
   map_item_type   map_item;
   logic           fetch_valid, fetch_ready;
   fetch_item_type fetch_item;
   logic [7:0]     rd_data;

   // register file; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_x     <= '0;
         cfg_ff.offset_z     <= '0;
         cfg_ff.inv_scale_x  <= INV_SCALE_RESET;
         cfg_ff.inv_scale_z  <= INV_SCALE_RESET;
         cfg_ff.out_gain     <= OUT_GAIN_RESET;
         cfg_ff.out_offset_y <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_OFFSET_X:     cfg_ff.offset_x     <= csr_wdata;
            REG_OFFSET_Z:     cfg_ff.offset_z     <= csr_wdata;
            REG_INV_SCALE_X:  cfg_ff.inv_scale_x  <= csr_wdata[23:0];
            REG_INV_SCALE_Z:  cfg_ff.inv_scale_z  <= csr_wdata[23:0];
            REG_OUT_GAIN:     cfg_ff.out_gain     <= csr_wdata[23:0];
            REG_OUT_OFFSET_Y: cfg_ff.out_offset_y <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = !in_ready;

   // coordinate mapping: delta, scale, map size and range check
   hbs_texel_map u_map (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (req_valid),
      .in_ready       (in_ready),
      .in_func        (func_type'(req_func)),
      .in_texel_addr  (req_texel_addr),
      .in_texel_value (req_texel_value),
      .in_query_x     (req_query_x),
      .in_query_z     (req_query_z),
      .map_valid      (map_valid),
      .map_ready      (map_ready),
      .map_item       (map_item)
   );

   // heightmap access: texel writes and four reads per query inside the map
   hbs_fetch u_fetch (
      .clock       (clock),
      .reset       (reset),
      .map_valid   (map_valid),
      .map_ready   (map_ready),
      .map_item    (map_item),
      .fetch_valid (fetch_valid),
      .fetch_ready (fetch_ready),
      .fetch_item  (fetch_item),
      .rd_data     (rd_data)
   );

   // interpolation, gain, offset and the output register
   hbs_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .fetch_valid (fetch_valid),
      .fetch_ready (fetch_ready),
      .fetch_item  (fetch_item),
      .rd_data     (rd_data),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_height  (rsp_terrain_height),
      .out_outside (rsp_outside)
   );

`ifndef SYNTHESIS
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside |-> rsp_terrain_height == 32'sd0)
      else $error("outside result carries a nonzero height");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_fetch_to_query: assert property (@(posedge clock) disable iff (reset)
      fetch_valid && !fetch_ready |=> fetch_valid)
      else $error("finished query dropped from fetch stage");
`endif

endmodule

// ===== hw/rtl/hbs_heightmap_ram.sv =====
`timescale 1ns / 1ps
module hbs_heightmap_ram
   import hbs_pkg::*;
(
   input  logic          clock,
   input  logic          rd_en,
   input  logic          wr_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);

   logic [7:0] mem [HM_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/hbs_texel_map.sv =====
`timescale 1ns / 1ps
module hbs_texel_map
   import hbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  func_type           in_func,
   input  logic [AW-1:0]      in_texel_addr,
   input  logic [7:0]         in_texel_value,
   input  logic signed [31:0] in_query_x,
   input  logic signed [31:0] in_query_z,
   output logic               map_valid,
   input  logic               map_ready,
   output map_item_type       map_item
);

   // stage a: deltas
   logic               a_valid_ff, a_valid_in;
   func_type           a_func_ff;
   logic [AW-1:0]      a_addr_ff;
   logic [7:0]         a_value_ff;
   logic signed [32:0] a_dx_ff, a_dz_ff;
   // stage b: scaled deltas
   logic               b_valid_ff, b_valid_in;
   func_type           b_func_ff;
   logic [AW-1:0]      b_addr_ff;
   logic [7:0]         b_value_ff;
   logic               b_out_ff;
   logic [PROD_W-1:0]  b_px_ff, b_pz_ff;
   // stage c
   logic               c_valid_ff, c_valid_in;
   map_item_type       c_item_ff, c_item_in;

   logic a_ready, b_ready, c_ready;
   logic [FXW-1:0] fpx;
   logic [FZW-1:0] fpz;
   logic [PXW-1:0] px;
   logic [PZW-1:0] pz;
   logic           out_x, out_z;

   assign c_ready  = !c_valid_ff || map_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign a_valid_in = a_ready ? in_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_func_ff  <= in_func;
         a_addr_ff  <= in_texel_addr;
         a_value_ff <= in_texel_value;
         a_dx_ff    <= 33'(in_query_x) - 33'(cfg.offset_x);
         a_dz_ff    <= 33'(in_query_z) - 33'(cfg.offset_z);
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_func_ff  <= a_func_ff;
         b_addr_ff  <= a_addr_ff;
         b_value_ff <= a_value_ff;
         b_out_ff   <= a_dx_ff[32] || (a_dx_ff == 33'sd0) ||
                       a_dz_ff[32] || (a_dz_ff == 33'sd0);
         b_px_ff    <= PROD_W'(a_dx_ff[31:0]) * PROD_W'(cfg.inv_scale_x);
         b_pz_ff    <= PROD_W'(a_dz_ff[31:0]) * PROD_W'(cfg.inv_scale_z);
      end
   end

   // multiply by the map size and drop sixteen fraction bits
   assign fpx   = FXW'(b_px_ff) * FXW'(MAP_WIDTH);
   assign fpz   = FZW'(b_pz_ff) * FZW'(MAP_HEIGHT);
   assign px    = fpx[FXW-1:16];
   assign pz    = fpz[FZW-1:16];
   assign out_x = (px == '0) || (px >= (PXW'(MAP_WIDTH) << 16));
   assign out_z = (pz == '0) || (pz >= (PZW'(MAP_HEIGHT) << 16));

   always_comb begin
      c_item_in.func        = b_func_ff;
      c_item_in.texel_addr  = b_addr_ff;
      c_item_in.texel_value = b_value_ff;
      c_item_in.outside     = b_out_ff || out_x || out_z;
      c_item_in.ix          = px[16+XW-1:16];
      c_item_in.iz          = pz[16+ZW-1:16];
      c_item_in.fx          = px[15:0];
      c_item_in.fz          = pz[15:0];
   end

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) begin
         c_item_ff <= c_item_in;
      end
   end

   assign map_valid = c_valid_ff;
   assign map_item  = c_item_ff;

endmodule

// ===== hw/rtl/hbs_fetch.sv =====
`timescale 1ns / 1ps
module hbs_fetch
   import hbs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           map_valid,
   output logic           map_ready,
   input  map_item_type   map_item,
   output logic           fetch_valid,
   input  logic           fetch_ready,
   output fetch_item_type fetch_item,
   output logic [7:0]     rd_data
);

   logic          f_valid_ff, f_valid_in;
   logic [2:0]    cnt_ff, cnt_in;
   func_type      func_ff;
   logic [7:0]    value_ff;
   logic [AW-1:0] waddr_ff;
   logic [AW-1:0] raddr_ff [4];
   logic [AW-1:0] raddr_in [4];
   fetch_item_type item_ff;

   logic          is_read, done, handoff, f_ready;
   logic          ram_rd, ram_wr;
   logic [AW-1:0] ram_addr;
   logic [XW-1:0] ix1;
   logic [ZW-1:0] iz1;

   assign is_read = (func_ff == FUNC_QUERY) && !item_ff.outside;
   assign done    = !is_read || (cnt_ff >= 3'd3);
   assign handoff = f_valid_ff && done && ((func_ff == FUNC_WRITE) || fetch_ready);
   assign f_ready = !f_valid_ff || handoff;
   assign map_ready = f_ready;

   assign f_valid_in = f_ready ? map_valid : f_valid_ff;

   always_comb begin
      if (f_ready) begin
         cnt_in = 3'd0;
      end else if (f_valid_ff && is_read && (cnt_ff < 3'd4)) begin
         cnt_in = cnt_ff + 3'd1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         cnt_ff     <= 3'd0;
      end else begin
         f_valid_ff <= f_valid_in;
         cnt_ff     <= cnt_in;
      end
   end

   // clamp the neighbours at the far edges
   assign ix1 = (32'(map_item.ix) + 1 < MAP_WIDTH) ? XW'(32'(map_item.ix) + 1)
                                                   : XW'(MAP_WIDTH - 1);
   assign iz1 = (32'(map_item.iz) + 1 < MAP_HEIGHT) ? ZW'(32'(map_item.iz) + 1)
                                                    : ZW'(MAP_HEIGHT - 1);

   always_comb begin
      raddr_in[0] = AW'(32'(map_item.iz) * MAP_WIDTH + 32'(map_item.ix));
      raddr_in[1] = AW'(32'(map_item.iz) * MAP_WIDTH + 32'(ix1));
      raddr_in[2] = AW'(32'(iz1) * MAP_WIDTH + 32'(map_item.ix));
      raddr_in[3] = AW'(32'(iz1) * MAP_WIDTH + 32'(ix1));
   end

   always_ff @(posedge clock) begin
      if (f_ready && map_valid) begin
         func_ff         <= map_item.func;
         value_ff        <= map_item.texel_value;
         waddr_ff        <= map_item.texel_addr;
         raddr_ff        <= raddr_in;
         item_ff.outside <= map_item.outside;
         item_ff.fx      <= map_item.fx;
         item_ff.fz      <= map_item.fz;
      end else if (f_valid_ff && is_read) begin
         case (cnt_ff)
            3'd1:    item_ff.h00 <= rd_data;
            3'd2:    item_ff.h10 <= rd_data;
            3'd3:    item_ff.h01 <= rd_data;
            default: ;
         endcase
      end
   end

   // one read per cycle; the fourth read stays in the read register
   assign ram_rd   = f_valid_ff && is_read && (cnt_ff < 3'd4);
   assign ram_wr   = f_valid_ff && (func_ff == FUNC_WRITE);
   assign ram_addr = ram_wr ? waddr_ff : raddr_ff[cnt_ff[1:0]];

   hbs_heightmap_ram u_ram (
      .clock (clock),
      .rd_en (ram_rd),
      .wr_en (ram_wr),
      .addr  (ram_addr),
      .wdata (value_ff),
      .rdata (rd_data)
   );

   assign fetch_valid = f_valid_ff && done && (func_ff == FUNC_QUERY);

   // the third texel is still on the read port in the cycle its read completes
   always_comb begin
      fetch_item = item_ff;
      if (cnt_ff == 3'd3) begin
         fetch_item.h01 = rd_data;
      end
   end

endmodule

// ===== hw/rtl/hbs_blend.sv =====
`timescale 1ns / 1ps
module hbs_blend
   import hbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               fetch_valid,
   output logic               fetch_ready,
   input  fetch_item_type     fetch_item,
   input  logic [7:0]         rd_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [31:0] out_height,
   output logic               out_outside
);

   localparam logic signed [33:0] H_MAX = 34'sd2147483647;
   localparam logic signed [33:0] H_MIN = -34'sd2147483648;

   // stage d: texels
   logic           d_valid_ff, d_valid_in, need_ff;
   fetch_item_type d_item_ff;
   logic [7:0]     h11_ff;
   // stage e: row values
   logic               e_valid_ff, e_valid_in, e_out_ff;
   logic [15:0]        e_fz_ff;
   logic signed [26:0] e_top_ff, e_bot_ff;
   // stage f: blended height
   logic        f_valid_ff, f_valid_in, f_out_ff;
   logic [23:0] f_hq_ff;
   // stage g: gain
   logic        g_valid_ff, g_valid_in, g_out_ff;
   logic [47:0] g_m_ff;
   // stage h: result
   logic               h_valid_ff, h_valid_in, h_out_ff;
   logic signed [31:0] h_height_ff;

   logic d_ready, d_go, e_ready, f_ready, g_ready, h_ready;
   logic signed [26:0] top, bot, dt;
   logic signed [44:0] v, vr;
   logic [24:0]        hg;
   logic signed [33:0] sum;
   logic signed [31:0] sat;

   assign h_ready = !h_valid_ff || out_ready;
   assign g_ready = !g_valid_ff || h_ready;
   assign f_ready = !f_valid_ff || g_ready;
   assign e_ready = !e_valid_ff || f_ready;
   assign d_go    = d_valid_ff && !need_ff;
   assign d_ready = !d_valid_ff || (!need_ff && e_ready);
   assign fetch_ready = d_ready;

   assign d_valid_in = d_ready ? fetch_valid : d_valid_ff;
   assign e_valid_in = e_ready ? d_go : e_valid_ff;
   assign f_valid_in = f_ready ? e_valid_ff : f_valid_ff;
   assign g_valid_in = g_ready ? f_valid_ff : g_valid_ff;
   assign h_valid_in = h_ready ? g_valid_ff : h_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         need_ff    <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
         need_ff    <= d_ready && fetch_valid;
         e_valid_ff <= e_valid_in;
         f_valid_ff <= f_valid_in;
         g_valid_ff <= g_valid_in;
         h_valid_ff <= h_valid_in;
      end
   end

   // the last texel sits on the read port in the cycle after the handoff
   always_ff @(posedge clock) begin
      if (d_ready && fetch_valid) begin
         d_item_ff <= fetch_item;
      end
      if (need_ff) begin
         h11_ff <= rd_data;
      end
   end

   assign top = (27'(d_item_ff.h00) <<< 16) +
                (($signed({1'b0, d_item_ff.h10}) - $signed({1'b0, d_item_ff.h00})) *
                 $signed({1'b0, d_item_ff.fx}));
   assign bot = (27'(d_item_ff.h01) <<< 16) +
                (($signed({1'b0, h11_ff}) - $signed({1'b0, d_item_ff.h01})) *
                 $signed({1'b0, d_item_ff.fx}));

   always_ff @(posedge clock) begin
      if (e_ready && d_go) begin
         e_out_ff <= d_item_ff.outside;
         e_fz_ff  <= d_item_ff.fz;
         e_top_ff <= top;
         e_bot_ff <= bot;
      end
   end

   assign dt = e_bot_ff - e_top_ff;
   assign v  = (45'(e_top_ff) <<< 16) + 45'(dt * $signed({1'b0, e_fz_ff}));
   assign vr = v + 45'sd32768;

   always_ff @(posedge clock) begin
      if (f_ready && e_valid_ff) begin
         f_out_ff <= e_out_ff;
         f_hq_ff  <= vr[39:16];
      end
   end

   always_ff @(posedge clock) begin
      if (g_ready && f_valid_ff) begin
         g_out_ff <= f_out_ff;
         g_m_ff   <= 48'(f_hq_ff) * 48'(cfg.out_gain);
      end
   end

   assign hg  = 25'((49'(g_m_ff) + 49'd8388608) >> 24);
   assign sum = $signed({9'b0, hg}) + 34'(cfg.out_offset_y);

   always_comb begin
      if (sum > H_MAX) begin
         sat = 32'sh7fffffff;
      end else if (sum < H_MIN) begin
         sat = -32'sh80000000;
      end else begin
         sat = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (h_ready && g_valid_ff) begin
         h_out_ff    <= g_out_ff;
         h_height_ff <= g_out_ff ? 32'sd0 : sat;
      end
   end

   assign out_valid   = h_valid_ff;
   assign out_height  = h_height_ff;
   assign out_outside = h_out_ff;

endmodule
